>>> rtl/core/chip8_instruction_core_macros.svh
// Assertion macros shared by the instruction core.
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH
// Assert an implication on the core clock, disabled in reset.
`define C8_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c8 check failed");
// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define C8_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c8 check failed");
`endif

>>> rtl/core/c8_pkg.sv
// Package with types and constants of the CHIP-8 instruction core.
package c8_pkg;
    localparam int MEM_BYTES = 4096;
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_STEP = 2'd1;
    localparam logic [1:0] FUNC_PIX  = 2'd2;
    localparam logic [11:0] ADDR_MASK = 12'h0FFF;
    localparam logic [11:0] PC_START  = 12'h200;
    localparam logic [11:0] NNN_CLS   = 12'h0E0;
    localparam logic [11:0] NNN_RET   = 12'h0EE;
    localparam logic [3:0]  OP_SYS    = 4'h0;
    localparam logic [3:0]  OP_JP     = 4'h1;
    localparam logic [3:0]  OP_CALL   = 4'h2;
    localparam logic [3:0]  OP_LD     = 4'h6;
    localparam logic [3:0]  OP_ADD    = 4'h7;
    localparam logic [3:0]  OP_LDI    = 4'hA;
    localparam logic [3:0]  OP_DRW    = 4'hD;
    localparam int CFG_WIDTH  = 0;
    localparam int CFG_HEIGHT = 1;
endpackage

>>> rtl/core/c8_ram.sv
// Generic single-port RAM with registered read.
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> rtl/core/chip8_instruction_core.sv
// CHIP-8 instruction core: one load, pixel read or instruction step per transaction.
// A step fetches both opcode bytes, then executes; a return also reads the stack. A draw
// first reduces VX and VY modulo the screen size by repeated subtraction, then reads each
// sprite row and reads and writes each pixel; a clear rewrites every display bit.
// One transaction is in flight at a time. Reset (i_rst_n low, synchronous) clears registers
// and starts a pass that zeroes the display, one 1-bit word per cycle, before tready rises.
`include "chip8_instruction_core_macros.svh"
module chip8_instruction_core
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = 12,
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_HEIGHT  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], address[13:2], write_data[21:14], zero pad to 24 bits
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // opcode[15:0], next_pc[27:16], pixel_value[28], flag_value[36:29],
    // stack_fault[37], zero pad to 40 bits
    output logic [39:0] m_axis_tdata
);
    localparam int FRAME = MAX_WIDTH * MAX_HEIGHT;
    localparam int MAW   = $clog2(MEM_BYTES);
    localparam int FAW   = $clog2(FRAME);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int SDW   = $clog2(STACK_DEPTH + 1);

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_WAIT  = 14'b00000000000100,
        S_FH    = 14'b00000000001000,
        S_FL    = 14'b00000000010000,
        S_EXEC  = 14'b00000000100000,
        S_RET   = 14'b00000001000000,
        S_DXM   = 14'b00000010000000,
        S_DYM   = 14'b00000100000000,
        S_DROW  = 14'b00001000000000,
        S_DRD   = 14'b00010000000000,
        S_DPIX  = 14'b00100000000000,
        S_DWR   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [6:0]  r_w;
    logic [5:0]  r_h;
    logic [1:0]  r_func;
    logic [11:0] r_addr;
    logic [7:0]  r_wdata;
    logic [11:0] r_pc, r_i;
    logic [15:0] r_op;
    logic [7:0]  r_v [16];
    logic [SDW-1:0] r_sp;
    logic        r_fault, r_pix;
    logic        r_pix_pend;
    logic [FAW:0] r_cnt;
    logic [7:0]  r_sx, r_sy;
    logic [6:0]  r_x;
    logic [5:0]  r_y;
    logic [3:0]  r_row;
    logic [2:0]  r_bit;
    logic [7:0]  r_bits;
    logic        r_ovalid;
    logic [39:0] r_odata;

    // Clamped screen size.
    logic [6:0] w_c;
    logic [5:0] h_c;
    always_comb begin
        w_c = (r_w == 7'd0) ? 7'd1 :
              ({25'd0, r_w} > MAX_WIDTH) ? 7'(MAX_WIDTH) : r_w;
        h_c = (r_h == 6'd0) ? 6'd1 :
              ({26'd0, r_h} > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : r_h;
    end

    // Program memory port.
    logic           m_we;
    logic [MAW-1:0] m_addr;
    logic [7:0]     m_rdata;
    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(r_wdata),
        .o_rdata(m_rdata)
    );

    // Display memory port.
    logic           f_we, f_wd;
    logic [FAW-1:0] f_addr;
    logic           f_rdata;
    c8_ram #(.WIDTH(1), .DEPTH(FRAME)) u_frame (
        .i_clk(i_clk), .i_we(f_we), .i_addr(f_addr), .i_wdata(f_wd),
        .o_rdata(f_rdata)
    );

    // Return stack memory; a call pushes the advanced program counter.
    logic           s_we;
    logic [SAW-1:0] s_addr;
    logic [11:0]    s_rdata;
    logic [11:0]    pc2;
    assign pc2 = r_pc + 12'd2;
    c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(pc2),
        .o_rdata(s_rdata)
    );

    // Shared unit: one compare-and-subtract step for the coordinate modulo.
    logic [7:0] sub_a, sub_b, sub_d;
    logic       sub_ge;
    assign sub_d  = sub_a - sub_b;
    assign sub_ge = sub_a >= sub_b;

    // Pixel address y*w + x; w <= MAX_WIDTH so shift-free product stays narrow.
    logic [12:0] pos;
    assign pos = 13'(r_y) * 13'(w_c) + 13'(r_x);

    logic [3:0] opx, opy;
    assign opx = r_op[11:8];
    assign opy = r_op[7:4];
    logic sbit;
    assign sbit = r_bits[r_bit];

    // Pixel bit lands in the first output cycle; hold it while the result waits.
    logic pix_now;
    assign pix_now = r_pix_pend ? f_rdata : r_pix;

    always_comb begin
        n_state = r_state;
        m_we = 1'b0;
        m_addr = r_addr[MAW-1:0];
        f_we = 1'b0;
        f_wd = 1'b0;
        f_addr = r_cnt[FAW-1:0];
        s_we = 1'b0;
        s_addr = SAW'(r_sp - SDW'(1));
        sub_a = r_sx;
        sub_b = {1'b0, w_c};
        unique case (r_state)
            S_CLR: begin
                f_we = 1'b1;
                // A clear opcode reports a result; the pass after reset does not.
                if (r_cnt == (FAW+1)'(FRAME - 1))
                    n_state = (r_op[15:12] == OP_SYS && r_op[11:0] == NNN_CLS) ?
                              S_OUT : S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_WAIT;
            end
            S_WAIT: begin
                m_we = (r_func == FUNC_LOAD);
                f_addr = r_addr[FAW-1:0];
                m_addr = r_pc[MAW-1:0];
                if (r_func == FUNC_LOAD) m_addr = r_addr[MAW-1:0];
                n_state = (r_func == FUNC_STEP) ? S_FH : S_OUT;
            end
            S_FH: begin
                m_addr = MAW'(r_pc + 12'd1);
                n_state = S_FL;
            end
            S_FL: n_state = S_EXEC;
            S_EXEC: begin
                unique case (r_op[15:12])
                    OP_SYS: begin
                        if (r_op[11:0] == NNN_CLS) n_state = S_CLR;
                        else if (r_op[11:0] == NNN_RET && r_sp != '0 &&
                                 r_sp <= SDW'(STACK_DEPTH)) n_state = S_RET;
                        else n_state = S_OUT;
                    end
                    OP_CALL: begin
                        s_addr = SAW'(r_sp);
                        s_we = (r_sp < SDW'(STACK_DEPTH));
                        n_state = S_OUT;
                    end
                    OP_DRW: n_state = S_DXM;
                    default: n_state = S_OUT;
                endcase
            end
            S_RET: n_state = S_OUT;
            S_DXM: begin
                if (!sub_ge) n_state = S_DYM;
            end
            S_DYM: begin
                sub_a = r_sy;
                sub_b = {2'b0, h_c};
                if (!sub_ge) n_state = (r_op[3:0] == 4'd0) ? S_OUT : S_DROW;
            end
            S_DROW: begin
                m_addr = MAW'(r_i + 12'(r_row));
                n_state = S_DRD;
            end
            S_DRD: n_state = S_DPIX;
            S_DPIX: begin
                f_addr = FAW'(pos);
                n_state = S_DWR;
            end
            S_DWR: begin
                f_addr = FAW'(pos);
                f_we = ({19'd0, pos} < FRAME);
                f_wd = f_rdata ^ sbit;
                if (r_bit != 3'd0 && (r_x + 7'd1) < w_c) n_state = S_DPIX;
                else if ((r_y + 6'd1) < h_c && (r_row + 4'd1) < r_op[3:0])
                    n_state = S_DROW;
                else n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt <= '0;
            r_w <= 7'd64;
            r_h <= 6'd32;
            r_pc <= PC_START;
            r_i <= '0;
            r_sp <= '0;
            r_ovalid <= 1'b0;
            r_fault <= 1'b0;
            r_pix <= 1'b0;
            r_op <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(CFG_WIDTH)) r_w <= i_cfg_data;
                else r_h <= i_cfg_data[5:0];
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: r_cnt <= r_cnt + 1'b1;
                S_IDLE: begin
                    r_func <= s_axis_tdata[1:0];
                    r_addr <= s_axis_tdata[13:2];
                    r_wdata <= s_axis_tdata[21:14];
                    r_op <= '0;
                    r_fault <= 1'b0;
                    r_pix <= 1'b0;
                    r_cnt <= '0;
                end
                S_WAIT: ;
                // High byte was read in the wait cycle, low byte in this one.
                S_FH: r_op[15:8] <= m_rdata;
                S_FL: r_op[7:0] <= m_rdata;
                S_EXEC: begin
                    r_sx <= r_v[opx];
                    r_sy <= r_v[opy];
                    unique case (r_op[15:12])
                        OP_SYS: begin
                            r_pc <= pc2;
                            if (r_op[11:0] == NNN_RET && (r_sp == '0 ||
                                r_sp > SDW'(STACK_DEPTH))) r_fault <= 1'b1;
                        end
                        OP_JP: r_pc <= r_op[11:0];
                        OP_CALL: begin
                            if (r_sp < SDW'(STACK_DEPTH)) begin
                                r_pc <= r_op[11:0];
                                r_sp <= r_sp + 1'b1;
                            end else begin
                                r_pc <= pc2;
                                r_fault <= 1'b1;
                            end
                        end
                        OP_LD: begin
                            r_pc <= pc2;
                            r_v[opx] <= r_op[7:0];
                        end
                        OP_ADD: begin
                            r_pc <= pc2;
                            r_v[opx] <= r_v[opx] + r_op[7:0];
                        end
                        OP_LDI: begin
                            r_pc <= pc2;
                            r_i <= r_op[11:0];
                        end
                        OP_DRW: begin
                            r_pc <= pc2;
                            r_v[15] <= 8'd0;
                        end
                        default: r_pc <= pc2;
                    endcase
                end
                S_RET: begin
                    r_pc <= s_rdata;
                    r_sp <= r_sp - 1'b1;
                end
                S_DXM: begin
                    if (sub_ge) r_sx <= sub_d;
                    else r_x <= sub_a[6:0];
                    r_row <= '0;
                end
                S_DYM: begin
                    if (sub_ge) r_sy <= sub_d;
                    else r_y <= sub_a[5:0];
                end
                S_DROW: ;
                S_DRD: begin
                    r_bits <= m_rdata;
                    r_bit <= 3'd7;
                end
                S_DPIX: ;
                S_DWR: begin
                    if ({19'd0, pos} < FRAME && sbit && f_rdata) r_v[15] <= 8'd1;
                    if (r_bit != 3'd0 && (r_x + 7'd1) < w_c) begin
                        r_bit <= r_bit - 1'b1;
                        r_x <= r_x + 1'b1;
                    end else begin
                        r_x <= r_sx[6:0];
                        r_y <= r_y + 1'b1;
                        r_row <= r_row + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata <= {2'b0, r_fault, r_v[15], pix_now, r_pc, r_op};
                    end
                end
                default: ;
            endcase
            if (r_state == S_EXEC && r_op[15:12] == OP_SYS &&
                r_op[11:0] == NNN_CLS) r_cnt <= '0;
            if (r_pix_pend) r_pix <= f_rdata;
        end
    end

    // Pixel bit lands in the cycle after its read; reads beyond the display answer 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_pend <= 1'b0;
        end else begin
            r_pix_pend <= (r_state == S_WAIT) && (r_func == FUNC_PIX) &&
                          ({20'd0, r_addr} < FRAME);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    `C8_ASSERT_IMP(a_ready_idle, s_axis_tready, r_state == S_IDLE)
    `C8_ASSERT_IMP(a_sp_range, 1'b1, r_sp <= SDW'(STACK_DEPTH))
    `C8_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
